// ----- rtl/lr_expression_recognizer_top_macros.svh -----
// assertion macros used by the expression recognizer parser
// expects clk_i and rst_ni in the scope of each use
`ifndef LR_EXPRESSION_RECOGNIZER_TOP_MACROS_SVH
`define LR_EXPRESSION_RECOGNIZER_TOP_MACROS_SVH

// checked only outside reset
`define LRER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define LRER_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/lrer_pkg.sv -----
// types, codes and parse tables of the expression recognizer
// no dependencies
package lrer_pkg;

  typedef enum logic [2:0] {
    TK_INT, TK_PLUS, TK_TIMES, TK_LP, TK_RP, TK_END
  } tok_e;

  typedef enum logic [1:0] {
    NT_E, NT_T, NT_F
  } nt_e;

  typedef enum logic [1:0] {
    A_ERR, A_SHIFT, A_REDUCE, A_ACCEPT
  } act_e;

  typedef struct packed {
    act_e       kind;
    logic [3:0] val;
  } act_t;

  // lexer view of one character
  typedef struct packed {
    logic is_digit;
    logic has_op;
    tok_e op;
    logic is_bad;
  } lex_t;

  typedef struct packed {
    logic [1:0] status;
    logic       done;
  } res_t;

  localparam logic [1:0] StPending  = 2'd0;
  localparam logic [1:0] StAccepted = 2'd1;
  localparam logic [1:0] StRejected = 2'd2;

  localparam logic [3:0] NoGo = 4'hF;

  function automatic act_t act_lookup(input logic [3:0] st, input tok_e tok);
    act_t a;
    a = '{kind: A_ERR, val: 4'd0};
    case (st) inside
      4'd0, 4'd4, 4'd6, 4'd7: begin
        if (tok == TK_INT) a = '{kind: A_SHIFT, val: 4'd5};
        else if (tok == TK_LP) a = '{kind: A_SHIFT, val: 4'd4};
      end
      4'd1: begin
        if (tok == TK_PLUS) a = '{kind: A_SHIFT, val: 4'd6};
        else if (tok == TK_END) a = '{kind: A_ACCEPT, val: 4'd0};
      end
      4'd2, 4'd9: begin
        if (tok == TK_TIMES) a = '{kind: A_SHIFT, val: 4'd7};
        else if (tok == TK_PLUS || tok == TK_RP || tok == TK_END)
          a = '{kind: A_REDUCE, val: (st == 4'd2) ? 4'd1 : 4'd0};
      end
      4'd3, 4'd5, 4'd10, 4'd11: begin
        if (tok == TK_PLUS || tok == TK_TIMES || tok == TK_RP || tok == TK_END) begin
          case (st) inside
            4'd3:    a = '{kind: A_REDUCE, val: 4'd3};
            4'd5:    a = '{kind: A_REDUCE, val: 4'd5};
            4'd10:   a = '{kind: A_REDUCE, val: 4'd2};
            default: a = '{kind: A_REDUCE, val: 4'd4};
          endcase
        end
      end
      4'd8: begin
        if (tok == TK_PLUS) a = '{kind: A_SHIFT, val: 4'd6};
        else if (tok == TK_RP) a = '{kind: A_SHIFT, val: 4'd11};
      end
      default: a = '{kind: A_ERR, val: 4'd0};
    endcase
    return a;
  endfunction

  function automatic logic [3:0] goto_lookup(input logic [3:0] st, input nt_e nt);
    logic [3:0] g;
    g = NoGo;
    case (st) inside
      4'd0, 4'd4: begin
        if (nt == NT_E) g = (st == 4'd0) ? 4'd1 : 4'd8;
        else if (nt == NT_T) g = 4'd2;
        else g = 4'd3;
      end
      4'd6: begin
        if (nt == NT_T) g = 4'd9;
        else if (nt == NT_F) g = 4'd3;
      end
      4'd7: begin
        if (nt == NT_F) g = 4'd10;
      end
      default: g = NoGo;
    endcase
    return g;
  endfunction

  function automatic logic [1:0] rule_len(input logic [2:0] rule);
    logic [1:0] n;
    case (rule) inside
      3'd0, 3'd2, 3'd4: n = 2'd3;
      3'd1, 3'd3, 3'd5: n = 2'd1;
      default:          n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic nt_e rule_lhs(input logic [2:0] rule);
    nt_e n;
    case (rule) inside
      3'd2, 3'd3: n = NT_T;
      3'd4, 3'd5: n = NT_F;
      default:    n = NT_E;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/lrer_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
module lrer_ram #(
  parameter int Width = 4,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/lrer_lexer.sv -----
// character classifier: digit, operator token, whitespace or bad character
// depends on lrer_pkg
module lrer_lexer (
  input  logic [7:0]      char_i,
  output lrer_pkg::lex_t  lex_o
);

  always_comb begin
    lex_o = '{is_digit: 1'b0, has_op: 1'b0, op: lrer_pkg::TK_INT, is_bad: 1'b0};
    case (char_i) inside
      [8'h30:8'h39]: lex_o.is_digit = 1'b1;
      8'h2B: begin
        lex_o.has_op = 1'b1;
        lex_o.op     = lrer_pkg::TK_PLUS;
      end
      8'h2A: begin
        lex_o.has_op = 1'b1;
        lex_o.op     = lrer_pkg::TK_TIMES;
      end
      8'h28: begin
        lex_o.has_op = 1'b1;
        lex_o.op     = lrer_pkg::TK_LP;
      end
      8'h29: begin
        lex_o.has_op = 1'b1;
        lex_o.op     = lrer_pkg::TK_RP;
      end
      // space, tab, lf, vt, ff, cr
      8'h20, [8'h09:8'h0D]: lex_o.is_bad = 1'b0;
      default: lex_o.is_bad = 1'b1;
    endcase
  end

endmodule

// ----- rtl/lrer_parser.sv -----
// shift/reduce sequencer: one table lookup per step, state stack in ram
// depends on lrer_pkg, lrer_ram and the assertion macro header
`include "lr_expression_recognizer_top_macros.svh"

module lrer_parser #(
  parameter int STACK_DEPTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lrer_pkg::lex_t  lex_i,
  input  logic            last_i,
  output logic            fin_valid_o,
  input  logic            fin_ready_i,
  output lrer_pkg::res_t  fin_res_o
);

  localparam int SpW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_ACT, S_GOTO, S_LAST, S_FIN
  } state_e;

  state_e           state_q;
  logic [SpW-1:0]   sp_q;
  logic [3:0]       top_q;
  lrer_pkg::tok_e   tok_q;
  lrer_pkg::nt_e    lhs_q;
  logic             base_q;
  logic             last_q;
  logic             end_q;
  logic             acc_q;
  logic             in_number_q;
  logic             failed_q;

  lrer_pkg::act_t   act;
  logic [1:0]       len;
  logic [SpW-1:0]   sp_pop;
  logic [SpW-1:0]   sp_inc;
  logic             full;
  logic [3:0]       below;
  logic [3:0]       rdata;
  logic [3:0]       goto_st;
  logic             we;
  logic [3:0]       wdata;

  assign act     = lrer_pkg::act_lookup(top_q, tok_q);
  assign len     = lrer_pkg::rule_len(act.val[2:0]);
  assign sp_pop  = sp_q - SpW'(len);
  assign sp_inc  = sp_q + 1'b1;
  assign full    = (sp_q == SpW'(STACK_DEPTH - 1));
  // entry zero is never written: the start state stands in for it when a pop reaches the base
  assign below   = base_q ? 4'd0 : rdata;
  assign goto_st = lrer_pkg::goto_lookup(below, lhs_q);

  assign we    = !full && (((state_q == S_ACT) && (act.kind == lrer_pkg::A_SHIFT)) ||
                           ((state_q == S_GOTO) && (goto_st != lrer_pkg::NoGo)));
  assign wdata = (state_q == S_ACT) ? act.val : goto_st;

  lrer_ram #(
    .Width (4),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (sp_inc),
    .wdata_i (wdata),
    .raddr_i (sp_pop),
    .rdata_o (rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign fin_valid_o = (state_q == S_FIN);

  always_comb begin
    fin_res_o.done = last_q;
    if (last_q) fin_res_o.status = acc_q ? lrer_pkg::StAccepted : lrer_pkg::StRejected;
    else        fin_res_o.status = failed_q ? lrer_pkg::StRejected : lrer_pkg::StPending;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      top_q       <= 4'd0;
      tok_q       <= lrer_pkg::TK_INT;
      lhs_q       <= lrer_pkg::NT_E;
      base_q      <= 1'b0;
      last_q      <= 1'b0;
      end_q       <= 1'b0;
      acc_q       <= 1'b0;
      in_number_q <= 1'b0;
      failed_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            last_q  <= last_i;
            end_q   <= 1'b0;
            acc_q   <= 1'b0;
            state_q <= S_LAST;
            if (!failed_q) begin
              if (lex_i.is_digit) begin
                in_number_q <= 1'b1;
                if (!in_number_q) begin
                  tok_q   <= lrer_pkg::TK_INT;
                  state_q <= S_ACT;
                end
              end else begin
                in_number_q <= 1'b0;
                if (lex_i.has_op) begin
                  tok_q   <= lex_i.op;
                  state_q <= S_ACT;
                end else if (lex_i.is_bad) begin
                  failed_q <= 1'b1;
                end
              end
            end
          end
        end
        S_ACT: begin
          unique case (act.kind)
            lrer_pkg::A_SHIFT: begin
              if (full) begin
                failed_q <= 1'b1;
              end else begin
                sp_q  <= sp_inc;
                top_q <= act.val;
              end
              state_q <= S_LAST;
            end
            lrer_pkg::A_REDUCE: begin
              if (sp_q < SpW'(len)) begin
                failed_q <= 1'b1;
                state_q  <= S_LAST;
              end else begin
                sp_q    <= sp_pop;
                lhs_q   <= lrer_pkg::rule_lhs(act.val[2:0]);
                base_q  <= (sp_pop == '0);
                state_q <= S_GOTO;
              end
            end
            lrer_pkg::A_ACCEPT: begin
              if (end_q) acc_q <= 1'b1;
              else       failed_q <= 1'b1;
              state_q <= S_LAST;
            end
            default: begin
              failed_q <= 1'b1;
              state_q  <= S_LAST;
            end
          endcase
        end
        S_GOTO: begin
          if (goto_st == lrer_pkg::NoGo || full) begin
            failed_q <= 1'b1;
            state_q  <= S_LAST;
          end else begin
            sp_q    <= sp_inc;
            top_q   <= goto_st;
            state_q <= S_ACT;
          end
        end
        S_LAST: begin
          // end token follows the final character unless already failed
          if (last_q && !failed_q && !end_q && !acc_q) begin
            end_q   <= 1'b1;
            tok_q   <= lrer_pkg::TK_END;
            state_q <= S_ACT;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_ready_i) begin
            state_q <= S_IDLE;
            if (last_q) begin
              sp_q        <= '0;
              top_q       <= 4'd0;
              in_number_q <= 1'b0;
              failed_q    <= 1'b0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `LRER_ASSERT(a_push_step, we |=> (sp_q == SpW'($past(sp_q) + 1'b1)), "push did not bump sp")
  `LRER_ASSERT(a_reinit, (state_q == S_FIN && fin_ready_i && last_q) |=> (sp_q == '0 && !failed_q && top_q == 4'd0), "no reinit after final item")
  `LRER_ASSERT(a_acc_only_end, acc_q |-> (end_q && last_q && !failed_q), "accept outside end token")
  `LRER_ASSERT_ALWAYS(a_write_state, we |-> (state_q == S_ACT || state_q == S_GOTO), "stack write outside step")

endmodule

// ----- rtl/lr_expression_recognizer_top.sv -----
// Sequence: a character that needs no token passes the idle, last and finish states; one that
//   shifts adds an action lookup, and each reduce adds a stack ram read and goto push; the final
//   character adds the end-token steps. The sequencer takes one character at a time, and a held
//   result stalls it in its finish state, which holds back the next character.
// Reset: asynchronous, active low; clears the sequencer, stack pointer and flags. The
//   stack ram is not cleared: entry zero is implied as the start state.
module lr_expression_recognizer_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tlast,   // last_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [1:0] status, [7:2] zero
  output logic       m_axis_tlast    // done_res
);

  lrer_pkg::lex_t lex;
  lrer_pkg::res_t fin_res;
  logic           fin_valid;
  logic           fin_ready;
  logic           m_valid_q;
  logic [1:0]     m_status_q;
  logic           m_last_q;

  lrer_lexer u_lexer (
    .char_i (s_axis_tdata),
    .lex_o  (lex)
  );

  assign fin_ready = !m_valid_q || m_axis_tready;

  lrer_parser #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .lex_i       (lex),
    .last_i      (s_axis_tlast),
    .fin_valid_o (fin_valid),
    .fin_ready_i (fin_ready),
    .fin_res_o   (fin_res)
  );

  // output register parts the result from the next item's work
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q  <= 1'b0;
      m_status_q <= lrer_pkg::StPending;
      m_last_q   <= 1'b0;
    end else begin
      if (fin_valid && fin_ready) begin
        m_valid_q  <= 1'b1;
        m_status_q <= fin_res.status;
        m_last_q   <= fin_res.done;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_status_q};
  assign m_axis_tlast  = m_last_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for lr_expression_recognizer_top: streams expression text in, checks each verdict
// against the file's parser model or a directed value; needs lrer_pkg and the recognizer rtl
module tb_top;

  localparam int Depth     = 32;
  localparam int ItemGoal  = 1300;
  localparam int QuietFrom = 1150;
  localparam int MaxPrints = 40;

  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChPlus  = "+";
  localparam logic [7:0] ChStar  = "*";
  localparam logic [7:0] ChLp    = "(";
  localparam logic [7:0] ChRp    = ")";
  localparam logic [7:0] ChZero  = "0";
  localparam logic [7:0] ChNine  = "9";

  // productions of the grammar
  localparam logic [3:0] PrSum        = 4'd0;  // E -> E + T
  localparam logic [3:0] PrExprTerm   = 4'd1;  // E -> T
  localparam logic [3:0] PrProd       = 4'd2;  // T -> T * F
  localparam logic [3:0] PrTermFactor = 4'd3;  // T -> F
  localparam logic [3:0] PrParen      = 4'd4;  // F -> ( E )
  localparam logic [3:0] PrInt        = 4'd5;  // F -> int

  typedef enum logic [1:0] {PR_MORE, PR_ACCEPT, PR_REJECT} parse_e;

  typedef struct packed {
    lrer_pkg::act_e kind;
    logic [3:0]     arg;
  } step_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       typed;
    logic [1:0] status;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;  // [7:0] char_code
  logic       s_axis_tlast = 1'b0;  // last_char
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [1:0] status, [7:2] zero
  logic       m_axis_tlast;         // done_res

  // parser model state
  logic [3:0]  pstack [Depth];
  int unsigned sp;
  bit          in_digits;
  bit          parse_failed;

  lrer_pkg::res_t verdict_q [$];
  logic [7:0]     text_q [$];
  row_t           script_q [$];

  int mismatches;
  int results_seen;
  int chars_sent;
  int exprs_sent;
  int accepts;
  int rejects;
  int overflows;
  int deepest;
  int drains;
  bit quiet;
  int gap_pct;

  lr_expression_recognizer_top #(
    .STACK_DEPTH(Depth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic step_t parse_action(input logic [3:0] st, input lrer_pkg::tok_e tk);
    step_t a;
    a = '{kind: lrer_pkg::A_ERR, arg: 4'd0};
    case (st)
      4'd0, 4'd4, 4'd6, 4'd7: begin
        if (tk == lrer_pkg::TK_INT) a = '{lrer_pkg::A_SHIFT, 4'd5};
        if (tk == lrer_pkg::TK_LP) a = '{lrer_pkg::A_SHIFT, 4'd4};
      end
      4'd1: begin
        if (tk == lrer_pkg::TK_PLUS) a = '{lrer_pkg::A_SHIFT, 4'd6};
        if (tk == lrer_pkg::TK_END) a = '{lrer_pkg::A_ACCEPT, 4'd0};
      end
      4'd2, 4'd9: begin
        if (tk == lrer_pkg::TK_TIMES) a = '{lrer_pkg::A_SHIFT, 4'd7};
        else if (tk == lrer_pkg::TK_PLUS || tk == lrer_pkg::TK_RP || tk == lrer_pkg::TK_END)
          a = '{lrer_pkg::A_REDUCE, (st == 4'd2) ? PrExprTerm : PrSum};
      end
      4'd8: begin
        if (tk == lrer_pkg::TK_PLUS) a = '{lrer_pkg::A_SHIFT, 4'd6};
        if (tk == lrer_pkg::TK_RP) a = '{lrer_pkg::A_SHIFT, 4'd11};
      end
      4'd3, 4'd5, 4'd10, 4'd11: begin
        // completed handles reduce on any follower token
        if (tk != lrer_pkg::TK_INT && tk != lrer_pkg::TK_LP) begin
          case (st)
            4'd3:    a = '{lrer_pkg::A_REDUCE, PrTermFactor};
            4'd5:    a = '{lrer_pkg::A_REDUCE, PrInt};
            4'd10:   a = '{lrer_pkg::A_REDUCE, PrProd};
            default: a = '{lrer_pkg::A_REDUCE, PrParen};
          endcase
        end
      end
      default: a = '{lrer_pkg::A_ERR, 4'd0};
    endcase
    return a;
  endfunction

  function automatic logic [3:0] goto_state(input logic [3:0] st, input lrer_pkg::nt_e nt);
    logic [3:0] g;
    g = lrer_pkg::NoGo;
    if (st == 4'd0 || st == 4'd4) begin
      case (nt)
        lrer_pkg::NT_E: g = (st == 4'd0) ? 4'd1 : 4'd8;
        lrer_pkg::NT_T: g = 4'd2;
        default:        g = 4'd3;
      endcase
    end else if (st == 4'd6 && nt != lrer_pkg::NT_E) begin
      g = (nt == lrer_pkg::NT_T) ? 4'd9 : 4'd3;
    end else if (st == 4'd7 && nt == lrer_pkg::NT_F) begin
      g = 4'd10;
    end
    return g;
  endfunction

  function automatic int unsigned prod_len(input logic [3:0] p);
    return (p == PrExprTerm || p == PrTermFactor || p == PrInt) ? 1 : 3;
  endfunction

  function automatic lrer_pkg::nt_e prod_lhs(input logic [3:0] p);
    case (p)
      PrSum, PrExprTerm:    return lrer_pkg::NT_E;
      PrProd, PrTermFactor: return lrer_pkg::NT_T;
      default:              return lrer_pkg::NT_F;
    endcase
  endfunction

  function automatic void clear_parser();
    for (int i = 0; i < Depth; i++) pstack[i] = 4'd0;
    sp = 0;
    in_digits = 1'b0;
    parse_failed = 1'b0;
  endfunction

  // one token: reduce until it shifts, is accepted or fails
  function automatic parse_e apply_token(input lrer_pkg::tok_e tk);
    step_t       a;
    int unsigned n;
    logic [3:0]  g;
    for (int guard = 0; guard < 4 * Depth + 16; guard++) begin
      a = parse_action(pstack[sp % Depth], tk);
      case (a.kind)
        lrer_pkg::A_SHIFT: begin
          if (sp + 1 >= Depth) begin
            overflows++;
            return PR_REJECT;
          end
          sp++;
          pstack[sp] = a.arg;
          if (sp > deepest) deepest = sp;
          return PR_MORE;
        end
        lrer_pkg::A_REDUCE: begin
          n = prod_len(a.arg);
          if (sp < n) return PR_REJECT;
          sp -= n;
          g = goto_state(pstack[sp], prod_lhs(a.arg));
          if (g == lrer_pkg::NoGo) return PR_REJECT;
          if (sp + 1 >= Depth) begin
            overflows++;
            return PR_REJECT;
          end
          sp++;
          pstack[sp] = g;
        end
        lrer_pkg::A_ACCEPT: return PR_ACCEPT;
        default:            return PR_REJECT;
      endcase
    end
    return PR_REJECT;
  endfunction

  function automatic lrer_pkg::res_t recognize_char(input logic [7:0] c, input bit last);
    parse_e         r;
    lrer_pkg::res_t o;
    r = PR_MORE;
    if (!parse_failed) begin
      if (c >= ChZero && c <= ChNine) begin
        // a digit run is one integer token, applied at its first digit
        if (!in_digits) r = apply_token(lrer_pkg::TK_INT);
        in_digits = 1'b1;
      end else begin
        in_digits = 1'b0;
        case (c)
          ChPlus:  r = apply_token(lrer_pkg::TK_PLUS);
          ChStar:  r = apply_token(lrer_pkg::TK_TIMES);
          ChLp:    r = apply_token(lrer_pkg::TK_LP);
          ChRp:    r = apply_token(lrer_pkg::TK_RP);
          ChSpace: r = PR_MORE;
          default: r = (c >= ChTab && c <= ChCr) ? PR_MORE : PR_REJECT;
        endcase
      end
      if (r != PR_MORE) parse_failed = 1'b1;
    end
    if (!last) begin
      o.status = parse_failed ? lrer_pkg::StRejected : lrer_pkg::StPending;
      o.done = 1'b0;
    end else begin
      o.status = lrer_pkg::StRejected;
      if (!parse_failed && apply_token(lrer_pkg::TK_END) == PR_ACCEPT)
        o.status = lrer_pkg::StAccepted;
      o.done = 1'b1;
      if (o.status == lrer_pkg::StAccepted) accepts++;
      else rejects++;
      clear_parser();
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    if (mismatches < MaxPrints)
      $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want_v, got_v);
    mismatches++;
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return ChPlus;
      1:       return ChStar;
      2:       return ChLp;
      default: return ChRp;
    endcase
  endfunction

  function automatic void maybe_blank();
    int unsigned k;
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, 6);
      text_q.insert(text_q.size(), 8'((k > 4) ? ChSpace : ChTab + k));
    end
  endfunction

  // well-formed expression with random numbers, nesting and spacing
  function automatic void build_expression(input int unsigned max_depth,
                                           input int unsigned n_terms, input bit dive);
    int unsigned lvl;
    lvl = 0;
    text_q.delete();
    for (int t = 0; t < n_terms; t++) begin
      while (lvl < max_depth && (dive && t == 0 || $urandom_range(0, 2) == 0)) begin
        text_q.insert(text_q.size(), ChLp);
        lvl++;
        maybe_blank();
      end
      repeat ($urandom_range(1, 3))
        text_q.insert(text_q.size(), 8'(ChZero + $urandom_range(0, 9)));
      maybe_blank();
      if (t != n_terms - 1) begin
        while (lvl > 0 && $urandom_range(0, 2) == 0) begin
          text_q.insert(text_q.size(), ChRp);
          lvl--;
          maybe_blank();
        end
        text_q.insert(text_q.size(), $urandom_range(0, 1) ? ChPlus : ChStar);
        maybe_blank();
      end
    end
    while (lvl > 0) begin
      text_q.insert(text_q.size(), ChRp);
      lvl--;
    end
  endfunction

  // break a sequence: overwrite, drop, insert or cut short
  function automatic void mangle_text();
    int unsigned pos;
    pos = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 3))
      0: text_q[pos] = 8'($urandom_range(0, 255));
      1: if (text_q.size() > 1) text_q.delete(pos);
      2: text_q.insert(pos, pick_operator());
      default: while (text_q.size() > pos + 1) void'(text_q.pop_back());
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
                           input lrer_pkg::res_t want);
    lrer_pkg::res_t guess;
    if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
    guess = recognize_char(c, last);
    verdict_q.insert(verdict_q.size(), typed ? want : guess);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++)
      send_char(text_q[i], i == text_q.size() - 1, 1'b0, '0);
    exprs_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    drains++;
  endtask

  // receiver: random stall bursts, calm stretches, no stalls once quiet
  initial begin : sink_ready
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 49) == 0) begin
          calm_left = $urandom_range(20, 100);
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 9);
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    lrer_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("item with nothing pending", 0, int'(m_axis_tdata));
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[1:0] != want.status)
          report_mismatch("status", int'(want.status), int'(m_axis_tdata[1:0]));
        if (m_axis_tlast != want.done)
          report_mismatch("done flag", int'(want.done), int'(m_axis_tlast));
        if (m_axis_tdata[7:2] != '0)
          report_mismatch("tdata padding", 0, int'(m_axis_tdata[7:2]));
        results_seen++;
      end
    end
  end

  initial begin : stimulus
    row_t        row;
    int unsigned pick;
    clear_parser();
    // directed rows: code, last, typed, status
    script_q.insert(script_q.size(), {"7",     1'b1, 1'b1, lrer_pkg::StAccepted});
    script_q.insert(script_q.size(), {"+",     1'b1, 1'b1, lrer_pkg::StRejected});
    script_q.insert(script_q.size(), {8'hFF,   1'b1, 1'b1, lrer_pkg::StRejected});
    script_q.insert(script_q.size(), {8'h00,   1'b1, 1'b1, lrer_pkg::StRejected});
    // empty text
    script_q.insert(script_q.size(), {ChSpace, 1'b1, 1'b1, lrer_pkg::StRejected});
    script_q.insert(script_q.size(), {"(",     1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {"1",     1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {")",     1'b1, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {"9",     1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {"*",     1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {ChTab,   1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {"0",     1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {"+",     1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {"1",     1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {"2",     1'b1, 1'b0, lrer_pkg::StPending});
    // two numbers in a row
    script_q.insert(script_q.size(), {"1",     1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {ChSpace, 1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {"2",     1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {"+",     1'b0, 1'b0, lrer_pkg::StPending});
    script_q.insert(script_q.size(), {"3",     1'b1, 1'b0, lrer_pkg::StPending});
    // bad character mid text
    script_q.insert(script_q.size(), {"a",     1'b0, 1'b1, lrer_pkg::StRejected});
    script_q.insert(script_q.size(), {"1",     1'b1, 1'b1, lrer_pkg::StRejected});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    gap_pct = 20;
    foreach (script_q[i]) begin
      row = script_q[i];
      send_char(row.code, row.last, row.typed, {row.status, row.last});
    end
    hold_until_drained();

    while (chars_sent < ItemGoal) begin
      if (chars_sent >= QuietFrom) quiet = 1'b1;
      gap_pct = $urandom_range(0, 3) * 15;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        text_q.delete();
        repeat ($urandom_range(1, 6))
          text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        // deep nesting around the stack limit
        build_expression($urandom_range(26, 40), $urandom_range(1, 3), 1'b1);
      end else begin
        build_expression($urandom_range(0, 4), $urandom_range(1, 6), 1'b0);
        if ($urandom_range(0, 99) < 20) mangle_text();
      end
      send_text();
      if (exprs_sent % 40 == 0) hold_until_drained();
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (verdict_q.size() != 0) report_mismatch("results never seen", 0, verdict_q.size());
    $display("summary: %0d expressions, %0d characters, %0d accepted, %0d rejected",
             exprs_sent, chars_sent, accepts, rejects);
    $display("summary: %0d results checked, deepest stack %0d, %0d overflows, %0d drains",
             results_seen, deepest, overflows, drains);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- lr_expression_recognizer_top.f -----
+incdir+rtl
rtl/lrer_pkg.sv
rtl/lrer_ram.sv
rtl/lrer_lexer.sv
rtl/lrer_parser.sv
rtl/lr_expression_recognizer_top.sv
bench/tb_top.sv
